// ===== rtl/core/qrot_pkg.sv =====
// Shared constants for the quaternion rotation datapath.
package qrot_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FIELD_W        = 32;
  localparam int Q_FRAC         = 30;

  // Hamilton product o = a * b: o[i] sums a[j] * b[i ^ j]; bit j set means subtract.
  localparam logic [3:0] HAM_NEG [4] = '{4'b1110, 4'b1000, 4'b0010, 4'b0100};

endpackage

// ===== rtl/core/qrot_ham.sv =====
// Two-stage pipelined fixed-point Hamilton product with rounding and saturation.
module qrot_ham #(
  parameter int WA = 32,
  parameter int WB = 33,
  parameter int SW = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic signed [WA-1:0] a [4],
  input  logic signed [WB-1:0] b [4],
  output logic                 out_valid,
  output logic signed [SW-1:0] o [4]
);
  import qrot_pkg::*;

  localparam int PW   = WA + WB;
  localparam int RW   = PW - Q_FRAC;
  localparam int SUMW = RW + 2;
  localparam logic signed [PW-1:0]   HALF = PW'(1) << (Q_FRAC - 1);
  localparam logic signed [SUMW-1:0] SMAX = {{(SUMW - SW + 1){1'b0}}, {(SW - 1){1'b1}}};
  localparam logic signed [SUMW-1:0] SMIN = {{(SUMW - SW + 1){1'b1}}, {(SW - 1){1'b0}}};

  logic signed [PW-1:0]   prod [4][4];
  logic                   prod_valid;
  logic signed [RW-1:0]   term [4][4];
  logic signed [SUMW-1:0] sum  [4];
  logic signed [SW-1:0]   sat  [4];

  // stage 1: sixteen exact products
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        prod[i][j] <= PW'(a[j]) * PW'(b[2'(i ^ j)]);
      end
    end
  end

  // stage 2: round half up to Q2.30, signed sum, clamp
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sum[i] = '0;
      for (int j = 0; j < 4; j++) begin
        term[i][j] = RW'((prod[i][j] + HALF) >>> Q_FRAC);
        if (HAM_NEG[i][j]) begin
          sum[i] = sum[i] - SUMW'(term[i][j]);
        end else begin
          sum[i] = sum[i] + SUMW'(term[i][j]);
        end
      end
      if (sum[i] > SMAX) begin
        sat[i] = SMAX[SW-1:0];
      end else if (sum[i] < SMIN) begin
        sat[i] = SMIN[SW-1:0];
      end else begin
        sat[i] = sum[i][SW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    o <= sat;
  end

endmodule

// ===== rtl/core/quaternion_rotate_unit.sv =====
// Rotates p by q as q * p * conj(q): done strobes once for each accepted start.
// Throughput one request per cycle outside reset; each rotation is two Hamilton products,
// each a multiply stage followed by a round, sum and saturate stage.
// busy is high only while rst is asserted; the receiver cannot stall the pipe.
// Synchronous reset clears the valid pipeline; data registers are not reset.
module quaternion_rotate_unit #(
  parameter int DATA_WIDTH = qrot_pkg::DATA_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 action,
  input  logic signed [qrot_pkg::FIELD_W-1:0]  q_w,
  input  logic signed [qrot_pkg::FIELD_W-1:0]  q_x,
  input  logic signed [qrot_pkg::FIELD_W-1:0]  q_y,
  input  logic signed [qrot_pkg::FIELD_W-1:0]  q_z,
  input  logic signed [qrot_pkg::FIELD_W-1:0]  p_w,
  input  logic signed [qrot_pkg::FIELD_W-1:0]  p_x,
  input  logic signed [qrot_pkg::FIELD_W-1:0]  p_y,
  input  logic signed [qrot_pkg::FIELD_W-1:0]  p_z,
  output logic                                 done,
  output logic signed [qrot_pkg::FIELD_W-1:0]  r_w,
  output logic signed [qrot_pkg::FIELD_W-1:0]  r_x,
  output logic signed [qrot_pkg::FIELD_W-1:0]  r_y,
  output logic signed [qrot_pkg::FIELD_W-1:0]  r_z
);
  import qrot_pkg::*;

  localparam int SW = (DATA_WIDTH > FIELD_W) ? FIELD_W : DATA_WIDTH;
  localparam int QCW = FIELD_W + 1;

  logic                      accept;
  logic signed [FIELD_W-1:0] p_in  [4];
  logic signed [QCW-1:0]     qc_in [4];
  logic signed [FIELD_W-1:0] q_d1  [4];
  logic signed [FIELD_W-1:0] q_d2  [4];
  logic [3:0]                act_d;
  logic                      t_valid;
  logic signed [SW-1:0]      t     [4];
  logic signed [SW-1:0]      r     [4];

  assign busy   = rst;
  assign accept = start && !busy;

  // real part of p is zero in vector mode; conj(q) needs one extra bit
  always_comb begin
    p_in[0]  = action ? p_w : '0;
    p_in[1]  = p_x;
    p_in[2]  = p_y;
    p_in[3]  = p_z;
    qc_in[0] = QCW'(q_w);
    qc_in[1] = -QCW'(q_x);
    qc_in[2] = -QCW'(q_y);
    qc_in[3] = -QCW'(q_z);
  end

  // q travels alongside the first product; the mode travels alongside both products
  always_ff @(posedge clk) begin
    q_d1 <= '{q_w, q_x, q_y, q_z};
    q_d2 <= q_d1;
    act_d <= {act_d[2:0], action};
  end

  qrot_ham #(
    .WA (FIELD_W),
    .WB (QCW),
    .SW (SW)
  ) u_ham_pqc (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .a         (p_in),
    .b         (qc_in),
    .out_valid (t_valid),
    .o         (t)
  );

  qrot_ham #(
    .WA (FIELD_W),
    .WB (SW),
    .SW (SW)
  ) u_ham_qt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (t_valid),
    .a         (q_d2),
    .b         (t),
    .out_valid (done),
    .o         (r)
  );

  assign r_w = act_d[3] ? FIELD_W'(r[0]) : '0;
  assign r_x = FIELD_W'(r[1]);
  assign r_y = FIELD_W'(r[2]);
  assign r_z = FIELD_W'(r[3]);

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##4 done)
    else $error("request did not produce a result after four cycles");

  a_done_has_request: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 4))
    else $error("result strobe without a matching request");

  a_vector_real_zero: assert property (@(posedge clk) disable iff (rst)
    (accept && !action) |-> ##4 (r_w == '0))
    else $error("vector mode result has non-zero real part");

endmodule
